// ----- rtl/circle_segment_crossing_test_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for circle_segment_crossing_test
// Shared concurrent assertion forms, clocked, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SEGMENT_CROSSING_TEST_MACROS_SVH
`define CIRCLE_SEGMENT_CROSSING_TEST_MACROS_SVH

// property checked only while out of reset
`define CSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Constants and shared types for the circle / segment crossing pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int COORD_WIDTH = 16;
    // register stages from accepted beat to result strobe
    localparam int LATENCY     = 6;

    // decision flags carried down the back half of the pipe
    typedef struct packed {
        logic valid;
        logic zero_len;   // segment endpoints coincide
        logic both_neg;   // both endpoints strictly inside
        logic both_pos;   // both endpoints strictly outside
        logic vertex_in;  // closest point parameter lies in [0,1]
    } t_sel;

endpackage

// ----- rtl/circle_segment_crossing_test.sv -----
// ----------------------------------------------------------------------------
// circle_segment_crossing_test
// Each accepted start beat yields its o_hit_valid strobe from the last stage.
// Throughput: one test per cycle; six register stages, busy is never raised.
// Reset: synchronous active low i_rst_n clears every stage valid bit, so no
// strobe follows reset until a new start beat has run the full pipe.
// ----------------------------------------------------------------------------
module circle_segment_crossing_test #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_centre_x,
    input  logic signed [COORD_WIDTH-1:0] i_centre_y,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    output logic                          o_hit_valid,
    output logic                          o_hit
);
    `include "circle_segment_crossing_test_macros.svh"

    // Method: p = start - centre, q = end - centre, d = q - p and
    // f(t) = |p + t*d|^2 - r^2. Opposite or zero endpoint signs mean a
    // crossing; both inside means none; both outside needs the vertex in
    // [0,1] and r^2*|d|^2 >= (d x p)^2. All compares are exact integers.

    logic                          w_valid;
    logic                          s1_valid, s1_zero;
    logic signed [COORD_WIDTH:0]   s1_px, s1_py, s1_qx, s1_qy, s1_dx, s1_dy;
    logic        [COORD_WIDTH-2:0] s1_r;
    csc_pkg::t_sel                 s3_sel;
    logic        [2*COORD_WIDTH:0] s3_r2, s3_kd, s3_cabs;

    // pipeline never stalls: every start beat is taken
    assign busy    = 1'b0;
    assign w_valid = start && !busy;

    // stage 1: differences
    csc_delta #(.COORD_WIDTH(COORD_WIDTH)) u_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_x1    (i_seg_start_x),
        .i_y1    (i_seg_start_y),
        .i_x2    (i_seg_end_x),
        .i_y2    (i_seg_end_y),
        .i_xc    (i_centre_x),
        .i_yc    (i_centre_y),
        .i_r     (i_radius),
        .o_valid (s1_valid),
        .o_zero  (s1_zero),
        .o_px    (s1_px),
        .o_py    (s1_py),
        .o_qx    (s1_qx),
        .o_qy    (s1_qy),
        .o_dx    (s1_dx),
        .o_dy    (s1_dy),
        .o_r     (s1_r)
    );

    // stages 2-3: products, signs, length and cross magnitude
    csc_quad #(.COORD_WIDTH(COORD_WIDTH)) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_zero  (s1_zero),
        .i_px    (s1_px),
        .i_py    (s1_py),
        .i_qx    (s1_qx),
        .i_qy    (s1_qy),
        .i_dx    (s1_dx),
        .i_dy    (s1_dy),
        .i_r     (s1_r),
        .o_sel   (s3_sel),
        .o_r2    (s3_r2),
        .o_kd    (s3_kd),
        .o_cabs  (s3_cabs)
    );

    // stages 4-6: wide discriminant compare and decision
    csc_disc #(.COORD_WIDTH(COORD_WIDTH)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (s3_sel),
        .i_r2    (s3_r2),
        .i_kd    (s3_kd),
        .i_cabs  (s3_cabs),
        .o_valid (o_hit_valid),
        .o_hit   (o_hit)
    );

    // a strobe only ever follows a start beat by the pipe latency
    `CSC_ASSERT(a_strobe_from_start, i_clk, i_rst_n, o_hit_valid |-> $past(start, csc_pkg::LATENCY), "result strobe without matching start beat")
    // hit is qualified by its strobe
    `CSC_ASSERT_ALWAYS(a_hit_qualified, i_clk, o_hit |-> o_hit_valid, "hit high outside a result beat")
    // a zero-length segment never reports a crossing
    `CSC_ASSERT(a_zero_len_miss, i_clk, i_rst_n, (start && i_seg_start_x == i_seg_end_x && i_seg_start_y == i_seg_end_y) |-> ##6 !o_hit, "hit on zero-length segment")

endmodule

// ----- rtl/csc_delta.sv -----
// ----------------------------------------------------------------------------
// csc_delta
// Stage 1: endpoint offsets from the centre and the segment direction.
// ----------------------------------------------------------------------------
module csc_delta #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_x1,
    input  logic signed [COORD_WIDTH-1:0] i_y1,
    input  logic signed [COORD_WIDTH-1:0] i_x2,
    input  logic signed [COORD_WIDTH-1:0] i_y2,
    input  logic signed [COORD_WIDTH-1:0] i_xc,
    input  logic signed [COORD_WIDTH-1:0] i_yc,
    input  logic        [COORD_WIDTH-2:0] i_r,
    output logic                          o_valid,
    output logic                          o_zero,
    output logic signed [COORD_WIDTH:0]   o_px,
    output logic signed [COORD_WIDTH:0]   o_py,
    output logic signed [COORD_WIDTH:0]   o_qx,
    output logic signed [COORD_WIDTH:0]   o_qy,
    output logic signed [COORD_WIDTH:0]   o_dx,
    output logic signed [COORD_WIDTH:0]   o_dy,
    output logic        [COORD_WIDTH-2:0] o_r
);
    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0] n_px, n_py, n_qx, n_qy, n_dx, n_dy;
    logic                 r_valid, r_zero;
    logic signed [DW-1:0] r_px, r_py, r_qx, r_qy, r_dx, r_dy;
    logic [COORD_WIDTH-2:0] r_r;

    always_comb begin
        n_px = DW'(i_x1) - DW'(i_xc);
        n_py = DW'(i_y1) - DW'(i_yc);
        n_qx = DW'(i_x2) - DW'(i_xc);
        n_qy = DW'(i_y2) - DW'(i_yc);
        n_dx = DW'(i_x2) - DW'(i_x1);
        n_dy = DW'(i_y2) - DW'(i_y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= (i_x1 == i_x2) && (i_y1 == i_y2);
        r_px   <= n_px;
        r_py   <= n_py;
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_r    <= i_r;
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_r     = r_r;

endmodule

// ----- rtl/csc_quad.sv -----
// ----------------------------------------------------------------------------
// csc_quad
// Stages 2-3: products of the offsets, then endpoint signs, vertex test,
// squared length and cross product magnitude.
// ----------------------------------------------------------------------------
module csc_quad #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_zero,
    input  logic signed [COORD_WIDTH:0]     i_px,
    input  logic signed [COORD_WIDTH:0]     i_py,
    input  logic signed [COORD_WIDTH:0]     i_qx,
    input  logic signed [COORD_WIDTH:0]     i_qy,
    input  logic signed [COORD_WIDTH:0]     i_dx,
    input  logic signed [COORD_WIDTH:0]     i_dy,
    input  logic        [COORD_WIDTH-2:0]   i_r,
    output csc_pkg::t_sel                   o_sel,
    output logic        [2*COORD_WIDTH:0]   o_r2,
    output logic        [2*COORD_WIDTH:0]   o_kd,
    output logic        [2*COORD_WIDTH:0]   o_cabs
);
    localparam int DW = COORD_WIDTH + 1;   // offset width
    localparam int PW = 2 * DW;            // signed product width
    localparam int SW = PW + 2;            // sum width with headroom
    localparam int KW = 2 * COORD_WIDTH + 1;
    localparam int RW = 2 * (COORD_WIDTH - 1);

    // stage 2
    logic                 r2_valid, r2_zero;
    logic signed [PW-1:0] r_pxx, r_pyy, r_qxx, r_qyy;
    logic signed [PW-1:0] r_dpx, r_dpy, r_dqx, r_dqy;
    logic signed [PW-1:0] r_dxx, r_dyy, r_cxy, r_cyx;
    logic        [RW-1:0] r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zero <= i_zero;
        r_pxx   <= i_px * i_px;
        r_pyy   <= i_py * i_py;
        r_qxx   <= i_qx * i_qx;
        r_qyy   <= i_qy * i_qy;
        r_dpx   <= i_dx * i_px;
        r_dpy   <= i_dy * i_py;
        r_dqx   <= i_dx * i_qx;
        r_dqy   <= i_dy * i_qy;
        r_dxx   <= i_dx * i_dx;
        r_dyy   <= i_dy * i_dy;
        r_cxy   <= i_dx * i_py;
        r_cyx   <= i_dy * i_px;
        r_rr    <= RW'(i_r) * RW'(i_r);
    end

    // stage 3
    logic signed [SW-1:0] n_f0, n_f1, n_dp, n_dq, n_kd, n_cr, n_cneg, n_r2s;
    csc_pkg::t_sel        n_sel, r_sel;
    logic        [KW-1:0] r_r2, r_kd, r_cabs;

    always_comb begin
        n_r2s           = SW'($signed({1'b0, r_rr}));
        n_f0            = SW'(r_pxx) + SW'(r_pyy) - n_r2s;
        n_f1            = SW'(r_qxx) + SW'(r_qyy) - n_r2s;
        n_dp            = SW'(r_dpx) + SW'(r_dpy);
        n_dq            = SW'(r_dqx) + SW'(r_dqy);
        n_kd            = SW'(r_dxx) + SW'(r_dyy);
        n_cr            = SW'(r_cxy) - SW'(r_cyx);
        n_cneg          = -n_cr;
        n_sel.valid     = r2_valid;
        n_sel.zero_len  = r2_zero;
        n_sel.both_neg  = (n_f0 < 0) && (n_f1 < 0);
        n_sel.both_pos  = (n_f0 > 0) && (n_f1 > 0);
        n_sel.vertex_in = (n_dp <= 0) && (n_dq >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel.valid <= 1'b0;
        end else begin
            r_sel.valid <= n_sel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel.zero_len  <= n_sel.zero_len;
        r_sel.both_neg  <= n_sel.both_neg;
        r_sel.both_pos  <= n_sel.both_pos;
        r_sel.vertex_in <= n_sel.vertex_in;
        r_r2            <= KW'(r_rr);
        r_kd            <= n_kd[KW-1:0];
        r_cabs          <= n_cr[SW-1] ? n_cneg[KW-1:0] : n_cr[KW-1:0];
    end

    assign o_sel  = r_sel;
    assign o_r2   = r_r2;
    assign o_kd   = r_kd;
    assign o_cabs = r_cabs;

endmodule

// ----- rtl/csc_disc.sv -----
// ----------------------------------------------------------------------------
// csc_disc
// Stages 4-6: r^2*|d|^2 against cross^2 as split partial products, then the
// final hit decision.
// ----------------------------------------------------------------------------
module csc_disc #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csc_pkg::t_sel                 i_sel,
    input  logic        [2*COORD_WIDTH:0] i_r2,
    input  logic        [2*COORD_WIDTH:0] i_kd,
    input  logic        [2*COORD_WIDTH:0] i_cabs,
    output logic                          o_valid,
    output logic                          o_hit
);
    localparam int KW = 2 * COORD_WIDTH + 1;
    localparam int H  = COORD_WIDTH + 1;   // low half width
    localparam int PP = 2 * H;             // partial product width
    localparam int AW = 2 * KW + 1;        // full product with carry room

    // stage 4: partial products
    csc_pkg::t_sel r4_sel, r5_sel;
    logic [PP-1:0] r_ahh, r_ahl, r_alh, r_all;
    logic [PP-1:0] r_bhh, r_bhl, r_blh, r_bll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_sel.valid <= 1'b0;
            r5_sel.valid <= 1'b0;
        end else begin
            r4_sel.valid <= i_sel.valid;
            r5_sel.valid <= r4_sel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sel.zero_len  <= i_sel.zero_len;
        r4_sel.both_neg  <= i_sel.both_neg;
        r4_sel.both_pos  <= i_sel.both_pos;
        r4_sel.vertex_in <= i_sel.vertex_in;
        r_ahh <= PP'(i_r2[KW-1:H]) * PP'(i_kd[KW-1:H]);
        r_ahl <= PP'(i_r2[KW-1:H]) * PP'(i_kd[H-1:0]);
        r_alh <= PP'(i_r2[H-1:0])  * PP'(i_kd[KW-1:H]);
        r_all <= PP'(i_r2[H-1:0])  * PP'(i_kd[H-1:0]);
        r_bhh <= PP'(i_cabs[KW-1:H]) * PP'(i_cabs[KW-1:H]);
        r_bhl <= PP'(i_cabs[KW-1:H]) * PP'(i_cabs[H-1:0]);
        r_blh <= PP'(i_cabs[H-1:0])  * PP'(i_cabs[KW-1:H]);
        r_bll <= PP'(i_cabs[H-1:0])  * PP'(i_cabs[H-1:0]);
    end

    // stage 5: recombine
    logic [AW-1:0] n_a, n_b, r_a, r_b;

    always_comb begin
        n_a = (AW'(r_ahh) << PP) + ((AW'(r_ahl) + AW'(r_alh)) << H) + AW'(r_all);
        n_b = (AW'(r_bhh) << PP) + ((AW'(r_bhl) + AW'(r_blh)) << H) + AW'(r_bll);
    end

    always_ff @(posedge i_clk) begin
        r5_sel.zero_len  <= r4_sel.zero_len;
        r5_sel.both_neg  <= r4_sel.both_neg;
        r5_sel.both_pos  <= r4_sel.both_pos;
        r5_sel.vertex_in <= r4_sel.vertex_in;
        r_a <= n_a;
        r_b <= n_b;
    end

    // stage 6: decision
    logic n_hit, r_valid, r_hit;

    always_comb begin
        priority if (r5_sel.zero_len) begin
            n_hit = 1'b0;
        end else if (r5_sel.both_neg) begin
            n_hit = 1'b0;
        end else if (!r5_sel.both_pos) begin
            n_hit = 1'b1;
        end else begin
            n_hit = r5_sel.vertex_in && (r_a >= r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= r5_sel.valid;
            r_hit   <= r5_sel.valid && n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

// ----- verif/circle_segment_crossing_test_checker.sv -----
// ----------------------------------------------------------------------------
// circle_segment_crossing_test_checker
// Watches accepted test beats, predicts the crossing flag with exact integer
// math and compares each o_hit_valid strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module circle_segment_crossing_test_checker #(
    parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_centre_x,
    input  logic signed [COORD_WIDTH-1:0] i_centre_y,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    input  logic                          o_hit_valid,
    input  logic                          o_hit,
    output int                            o_errors,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] t_wide;

    bit hit_q[$];
    int err_cnt = 0;
    int pend_cnt = 0;

    // exact boundary crossing decision, all products at 160 bits
    function automatic bit crossing_flag(
        logic signed [COORD_WIDTH-1:0] x1, logic signed [COORD_WIDTH-1:0] y1,
        logic signed [COORD_WIDTH-1:0] x2, logic signed [COORD_WIDTH-1:0] y2,
        logic signed [COORD_WIDTH-1:0] xc, logic signed [COORD_WIDTH-1:0] yc,
        logic [COORD_WIDTH-2:0] rad);
        t_wide px, py, qx, qy, dx, dy, r, r2, f0, f1, dp, dq, kd, cr, disc;
        px = t_wide'(x1) - t_wide'(xc);
        py = t_wide'(y1) - t_wide'(yc);
        qx = t_wide'(x2) - t_wide'(xc);
        qy = t_wide'(y2) - t_wide'(yc);
        dx = t_wide'(x2) - t_wide'(x1);
        dy = t_wide'(y2) - t_wide'(y1);
        r  = t_wide'({1'b0, rad});
        if (dx == 0 && dy == 0) return 1'b0;
        r2 = r * r;
        f0 = px * px + py * py - r2;
        f1 = qx * qx + qy * qy - r2;
        if (f0 < 0 && f1 < 0) return 1'b0;
        if (!(f0 > 0 && f1 > 0)) return 1'b1;
        // both ends outside: vertex must lie on the segment, then discriminant
        dp = dx * px + dy * py;
        dq = dx * qx + dy * qy;
        if (dp > 0 || dq < 0) return 1'b0;
        kd = dx * dx + dy * dy;
        cr = dx * py - dy * px;
        disc = r2 * kd - cr * cr;
        return disc >= 0;
    endfunction

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_hit_valid) begin
            if (hit_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < 10) $display("unexpected hit beat: %0b", o_hit);
            end else begin
                want = hit_q.pop_front();
                if (want !== o_hit) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10)
                        $display("hit mismatch: expected %0b actual %0b", want, o_hit);
                end
            end
        end
        if (i_rst_n && start && !busy)
            hit_q.push_back(crossing_flag(i_seg_start_x, i_seg_start_y, i_seg_end_x,
                                          i_seg_end_y, i_centre_x, i_centre_y, i_radius));
        pend_cnt <= hit_q.size();
    end
endmodule

// ----- verif/circle_segment_crossing_test_test.sv -----
// ----------------------------------------------------------------------------
// circle_segment_crossing_test_test
// Drives directed and random circle / segment tests into the pipe with random
// start gaps; the checker predicts and compares each hit beat.
// ----------------------------------------------------------------------------
module circle_segment_crossing_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = csc_pkg::COORD_WIDTH;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [W-1:0]  i_seg_start_x = '0, i_seg_start_y = '0;
    logic signed [W-1:0]  i_seg_end_x = '0, i_seg_end_y = '0;
    logic signed [W-1:0]  i_centre_x = '0, i_centre_y = '0;
    logic        [W-2:0]  i_radius = '0;
    logic                 o_hit_valid, o_hit;
    int                   errors, pending;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circle_segment_crossing_test uut (.*);

    circle_segment_crossing_test_checker chk (.*, .o_errors(errors), .o_pending(pending));

    // one accepted beat: drive, hold until start && !busy is seen at an edge;
    // values are cut to the field widths here
    task automatic send_test(input int x1, y1, x2, y2, xc, yc, rad);
        i_seg_start_x <= W'(x1);
        i_seg_start_y <= W'(y1);
        i_seg_end_x   <= W'(x2);
        i_seg_end_y   <= W'(y2);
        i_centre_x    <= W'(xc);
        i_centre_y    <= W'(yc);
        i_radius      <= (W-1)'(rad);
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // small coordinates make crossings likely; full range hits the extremes
    function automatic int near(input int base);
        return base + int'($urandom_range(0, 256)) - 128;
    endfunction

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int cx, cy;
        int kind;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero length, inside, endpoint on boundary, tangent,
        // zero radius on and off the segment, extremes of every field
        send_test(10, 10, 10, 10, 0, 0, 100);
        send_test(-5, 0, 5, 0, 0, 0, 100);
        send_test(100, 0, 200, 0, 0, 0, 100);
        send_test(-50, 20, 50, 20, 0, 0, 20);
        send_test(-50, 21, 50, 21, 0, 0, 20);
        send_test(60, 20, 90, 20, 0, 0, 20);
        send_test(-10, -10, 10, 10, 0, 0, 0);
        send_test(-10, -10, 10, 10, 1, 0, 0);
        send_test(-32768, -32768, 32767, 32767, 0, 0, 32767);
        send_test(-32768, -32768, 32767, 32767, 32767, -32768, 32767);
        send_test(32767, 32767, -32768, -32768, -32768, 32767, 0);
        send_test(-32768, 32767, 32767, -32768, 0, 0, 1);
        send_test(-300, 0, 300, 0, 0, 100, 100);
        send_test(-300, 0, 300, 0, 0, 101, 100);
        send_test(-1, -1, -1, -1, -1, -1, 32767);

        // hold off until the pipe drains
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 600; n++) begin
            if (n < 520 && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            kind = $urandom_range(0, 3);
            if (kind == 0) begin
                send_test(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom), int'($urandom));
            end else begin
                cx = int'($urandom_range(0, 2000)) - 1000;
                cy = int'($urandom_range(0, 2000)) - 1000;
                send_test(near(cx), near(cy), near(cx), near(cy), cx, cy,
                          int'($urandom_range(0, kind == 1 ? 20 : 180)));
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (csc_pkg::LATENCY + 4) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- circle_segment_crossing_test.f -----
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_delta.sv
rtl/csc_quad.sv
rtl/csc_disc.sv
rtl/circle_segment_crossing_test.sv
verif/circle_segment_crossing_test_checker.sv
verif/circle_segment_crossing_test_test.sv
